/* src/wmfm_pkg.sv */
// ----------------------------------------------------------------------------
// wmfm_pkg
// shared types and constants of the management frame monitor
// ----------------------------------------------------------------------------
package wmfm_pkg;

  localparam int unsigned LengthBits    = 12;
  localparam int unsigned HashedIeBytes = 24;

  localparam logic [LengthBits-1:0] PosMax     = '1;
  localparam logic [LengthBits-1:0] HdrLen     = LengthBits'(24);
  localparam logic [LengthBits-1:0] FcsLen     = LengthBits'(4);
  localparam logic [LengthBits-1:0] IeEnd      = LengthBits'(24 + HashedIeBytes);
  localparam logic [LengthBits-1:0] AddrFirst  = LengthBits'(10);
  localparam logic [LengthBits-1:0] AddrHashLast = LengthBits'(12);
  localparam logic [LengthBits-1:0] AddrLast   = LengthBits'(15);
  localparam logic [LengthBits-1:0] NoIeLen    = LengthBits'(28);

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  localparam logic [7:0] FcDeauth   = 8'hC0;
  localparam logic [7:0] FcDisassoc = 8'hA0;
  localparam logic [7:0] FcProbeReq = 8'h40;

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_e;

  typedef enum logic {
    KIND_SIGHTING = 1'b0,
    KIND_HEALTH   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_OTHER  = 2'd1,
    CLS_DEAUTH = 2'd2,
    CLS_PROBE  = 2'd3
  } frame_class_e;

  typedef struct packed {
    logic                  opcode;
    logic [7:0]            data_byte;
    logic                  last_byte;
    logic                  is_mgmt;
    logic [LengthBits-1:0] frame_length;
    logic signed [7:0]     signal_strength;
    logic [7:0]            radio_channel;
  } in_word_t;

  typedef struct packed {
    logic              result_kind;
    logic [47:0]       source_address;
    logic signed [7:0] sighting_rssi;
    logic [7:0]        sighting_channel;
    logic [15:0]       fingerprint;
    logic [15:0]       mgmt_tally;
    logic [15:0]       disconnect_tally;
    logic [7:0]        health_channel;
  } out_word_t;

endpackage

/* src/wifi_mgmt_frame_monitor.sv */
// ----------------------------------------------------------------------------
// wifi_mgmt_frame_monitor
// counts management frames and reports probe request sightings with a
// folded fnv-1a fingerprint of the transmitter oui and leading elements
// pipeline: input register, then result register; one word accepted per
//   cycle when the output drains
// throughput: 1 word per cycle when the output drains, set by the single fnv multiply-xor per byte
// reset: counters, byte position and frame class cleared, detection enabled,
//   both pipeline registers empty
// ----------------------------------------------------------------------------
module wifi_mgmt_frame_monitor
  import wmfm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  // config write channel
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  // byte stream in
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  // results out
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  // input register stage
  logic     in_valid_q;
  in_word_t in_q;

  // result register stage
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  // block state
  logic                  det_en_q;
  logic [15:0]           good_q, good_d;
  logic [15:0]           deauth_q, deauth_d;
  logic [7:0]            last_chan_q, last_chan_d;
  logic [LengthBits-1:0] pos_q, pos_d;
  frame_class_e          class_q, class_d;
  logic [31:0]           hash_q, hash_d;
  logic [47:0]           addr_q, addr_d;
  logic signed [7:0]     rssi_q, rssi_d;
  logic [7:0]            chan_q, chan_d;

  // working signals
  logic                  proc;
  logic                  is_drain;
  logic                  first;
  logic                  mix_en;
  logic                  ie_byte;
  logic [LengthBits:0]   pos_plus_fcs;
  logic [31:0]           hash_base;
  logic [31:0]           hash_mix;
  logic                  counted;
  logic                  emit_sight;

  // config is always taken; the user must change it only while the block is idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  // the held word moves on when the result slot is free or being emptied
  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  assign is_drain = (in_q.opcode == OP_DRAIN);
  assign first    = (pos_q == '0);

  // header byte 0 starts a fresh frame context
  assign hash_base = first ? FnvBasis : hash_q;

  // element bytes are hashed only inside the cap and before the fcs
  assign pos_plus_fcs = {1'b0, pos_q} + {1'b0, FcsLen};
  assign ie_byte = (pos_q >= HdrLen) && (pos_q < IeEnd)
                   && (pos_plus_fcs < {1'b0, in_q.frame_length});
  // first three address bytes feed the hash, i.e. the oui
  assign mix_en  = ((pos_q >= AddrFirst) && (pos_q <= AddrHashLast)) || ie_byte;

  // one constant multiply per byte, modulo 2^32
  assign hash_mix = (hash_base ^ {24'd0, in_q.data_byte}) * FnvPrime;

  always_comb begin
    class_d     = class_q;
    hash_d      = hash_base;
    addr_d      = first ? 48'd0 : addr_q;
    rssi_d      = first ? in_q.signal_strength : rssi_q;
    chan_d      = first ? in_q.radio_channel : chan_q;
    pos_d       = pos_q;
    good_d      = good_q;
    deauth_d    = deauth_q;
    last_chan_d = last_chan_q;
    counted     = 1'b0;
    emit_sight  = 1'b0;

    if (is_drain) begin
      // mid-frame context stays intact; only the counters clear
      good_d   = '0;
      deauth_d = '0;
    end else begin
      // classify on byte 0 from what is presented there
      if (first) begin
        if (!in_q.is_mgmt || (in_q.frame_length < HdrLen)) begin
          class_d = CLS_NONE;
        end else if ((in_q.data_byte == FcDeauth) || (in_q.data_byte == FcDisassoc)) begin
          class_d = CLS_DEAUTH;
        end else if (in_q.data_byte == FcProbeReq) begin
          class_d = CLS_PROBE;
        end else begin
          class_d = CLS_OTHER;
        end
      end

      // transmitter address, byte 10 ends up most significant
      if ((pos_q >= AddrFirst) && (pos_q <= AddrLast)) begin
        addr_d = {addr_d[39:0], in_q.data_byte};
      end

      if (mix_en) begin
        hash_d = hash_mix;
      end

      // position sticks at its maximum on an overlong frame
      if (pos_q != PosMax) begin
        pos_d = pos_q + LengthBits'(1);
      end

      if (in_q.last_byte) begin
        pos_d   = '0;
        counted = (class_d != CLS_NONE);
        if (counted) begin
          if (good_q != '1) begin
            good_d = good_q + 16'd1;
          end
          if ((class_d == CLS_DEAUTH) && (deauth_q != '1)) begin
            deauth_d = deauth_q + 16'd1;
          end
          last_chan_d = chan_d;
        end
        emit_sight = (class_d == CLS_PROBE) && det_en_q;
      end
    end
  end

  // result word build
  always_comb begin
    out_d = '0;
    if (is_drain) begin
      out_d.result_kind      = KIND_HEALTH;
      out_d.mgmt_tally       = good_q;
      out_d.disconnect_tally = deauth_q;
      out_d.health_channel   = last_chan_q;
    end else begin
      out_d.result_kind      = KIND_SIGHTING;
      out_d.source_address   = addr_d;
      out_d.sighting_rssi    = rssi_d;
      out_d.sighting_channel = chan_d;
      // fold to 16 bits; no element bytes means no fingerprint
      if (in_q.frame_length > NoIeLen) begin
        out_d.fingerprint = hash_d[31:16] ^ hash_d[15:0];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = is_drain || emit_sight;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      det_en_q    <= 1'b1;
      good_q      <= '0;
      deauth_q    <= '0;
      last_chan_q <= '0;
      pos_q       <= '0;
      class_q     <= CLS_NONE;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        det_en_q <= cfg_data_i;
      end
      if (proc) begin
        good_q      <= good_d;
        deauth_q    <= deauth_d;
        last_chan_q <= last_chan_d;
        pos_q       <= pos_d;
        class_q     <= class_d;
      end
    end
  end

  // payload registers, loaded before first use
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (proc) begin
      hash_q <= hash_d;
      addr_q <= addr_d;
      rssi_q <= rssi_d;
      chan_q <= chan_d;
      if (is_drain || emit_sight) begin
        out_q <= out_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* tb/sv/tb_wifi_mgmt_frame_monitor.sv */
// ----------------------------------------------------------------------------
// tb_wifi_mgmt_frame_monitor
// streams frames, health drains and detection-enable writes into the monitor,
// predicts every probe sighting and health sample, and checks each result
// word field by field, with both sides of the byte stream stalling at random in the idling phases
// ----------------------------------------------------------------------------
module tb_wifi_mgmt_frame_monitor;
  import wmfm_pkg::*;

  localparam int unsigned IeCap      = 256;     // element length clamp
  localparam logic [15:0] CountMax   = 16'hFFFF;
  localparam int unsigned StallLimit = 2000;    // cycles without any handshake
  localparam int unsigned SettleGap  = 4;       // cycles after the last result

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the monitor state, queue of results still owed
  // --------------------------------------------------------------------------
  class frame_monitor_sb;
    bit                    detect_en;
    logic [15:0]           good_cnt;
    logic [15:0]           deauth_cnt;
    logic [7:0]            last_chan;
    logic [LengthBits-1:0] pos;
    logic [31:0]           hash;
    logic [47:0]           addr;
    frame_class_e          cls;
    logic signed [7:0]     rssi_l;
    logic [7:0]            chan_l;
    out_word_t             due_reports[$];
    int unsigned           errors;

    function new();
      detect_en  = 1'b1;
      good_cnt   = '0;
      deauth_cnt = '0;
      last_chan  = '0;
      pos        = '0;
      hash       = FnvBasis;
      addr       = '0;
      cls        = CLS_NONE;
      rssi_l     = '0;
      chan_l     = '0;
      errors     = 0;
    endfunction

    function logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
      return (h ^ {24'd0, b}) * FnvPrime;
    endfunction

    // advance the monitor by one accepted word, queue the result it owes
    function void take_word(in_word_t w);
      out_word_t             r;
      logic [LengthBits-1:0] p;
      int unsigned           elem_len;
      int unsigned           k;
      r = '0;
      if (w.opcode == OP_DRAIN) begin
        r.result_kind      = KIND_HEALTH;
        r.mgmt_tally       = good_cnt;
        r.disconnect_tally = deauth_cnt;
        r.health_channel   = last_chan;
        good_cnt           = '0;
        deauth_cnt         = '0;
        due_reports.push_back(r);
        return;
      end
      p = pos;
      if (p == '0) begin
        hash   = FnvBasis;
        addr   = '0;
        rssi_l = w.signal_strength;
        chan_l = w.radio_channel;
        if (!w.is_mgmt || w.frame_length < HdrLen) begin
          cls = CLS_NONE;
        end else if (w.data_byte == FcDeauth || w.data_byte == FcDisassoc) begin
          cls = CLS_DEAUTH;
        end else if (w.data_byte == FcProbeReq) begin
          cls = CLS_PROBE;
        end else begin
          cls = CLS_OTHER;
        end
      end
      if (p >= AddrFirst && p <= AddrLast) addr = {addr[39:0], w.data_byte};
      if (p >= AddrFirst && p <= AddrHashLast) hash = fnv_step(hash, w.data_byte);
      elem_len = 0;
      if (w.frame_length > NoIeLen) elem_len = w.frame_length - NoIeLen;
      if (elem_len > IeCap) elem_len = IeCap;
      if (p >= HdrLen && p != PosMax) begin
        k = p - HdrLen;
        if (k < HashedIeBytes && k < elem_len) hash = fnv_step(hash, w.data_byte);
      end
      if (p != PosMax) pos = p + 1'b1;
      if (!w.last_byte) return;
      pos = '0;
      if (cls == CLS_NONE) return;
      if (good_cnt != CountMax) good_cnt++;
      last_chan = chan_l;
      if (cls == CLS_DEAUTH && deauth_cnt != CountMax) deauth_cnt++;
      if (cls != CLS_PROBE || !detect_en) return;
      r.result_kind      = KIND_SIGHTING;
      r.source_address   = addr;
      r.sighting_rssi    = rssi_l;
      r.sighting_channel = chan_l;
      r.fingerprint      = (elem_len > 0) ? (hash[31:16] ^ hash[15:0]) : 16'd0;
      due_reports.push_back(r);
    endfunction

    task report(string line);
      if (errors < 200) $display("mismatch: %s", line);
      errors++;
    endtask

    // compare one result word against the oldest one owed
    task match_report(out_word_t got);
      out_word_t want;
      if (due_reports.size() == 0) begin
        report($sformatf("result word with nothing owed: %h", got));
        return;
      end
      want = due_reports.pop_front();
      if (got.result_kind !== want.result_kind)
        report($sformatf("result_kind %0d want %0d", got.result_kind, want.result_kind));
      if (got.source_address !== want.source_address)
        report($sformatf("source_address %h want %h", got.source_address,
                         want.source_address));
      if (got.sighting_rssi !== want.sighting_rssi)
        report($sformatf("sighting_rssi %0d want %0d", got.sighting_rssi,
                         want.sighting_rssi));
      if (got.sighting_channel !== want.sighting_channel)
        report($sformatf("sighting_channel %0d want %0d", got.sighting_channel,
                         want.sighting_channel));
      if (got.fingerprint !== want.fingerprint)
        report($sformatf("fingerprint %h want %h", got.fingerprint, want.fingerprint));
      if (got.mgmt_tally !== want.mgmt_tally)
        report($sformatf("mgmt_tally %0d want %0d", got.mgmt_tally, want.mgmt_tally));
      if (got.disconnect_tally !== want.disconnect_tally)
        report($sformatf("disconnect_tally %0d want %0d", got.disconnect_tally,
                         want.disconnect_tally));
      if (got.health_channel !== want.health_channel)
        report($sformatf("health_channel %0d want %0d", got.health_channel,
                         want.health_channel));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, ports, instance
  // --------------------------------------------------------------------------
  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_data_o;

  always #5 clk_i = ~clk_i;

  wifi_mgmt_frame_monitor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  frame_monitor_sb sb;
  bit              idling_on;     // random bursts of idle on both sides
  int unsigned     words_sent;
  logic            moved;

  // frame lengths around the header, fcs and element-window boundaries
  int unsigned corner_lens[12] = '{0, 23, 24, 27, 28, 29, 51, 52, 53, 284, 285, 4095};

  assign moved = (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                 (cfg_valid_i && cfg_ready_o);

  // --------------------------------------------------------------------------
  // monitor: every handshake sampled at the rising edge
  // config and input first so a word is owed before its result can show up
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.detect_en = cfg_data_i;
      if (in_valid_i && in_ready_o) sb.take_word(in_data_i);
      if (out_valid_o && out_ready_i) sb.match_report(out_data_o);
    end
  end

  // result side back-pressure in random bursts while idling is on
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idling_on && $urandom_range(0, 15) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // watchdog: too long without any word moving means the block hung
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (moved) quiet = 0;
      else quiet++;
    end
    $display("tb_wifi_mgmt_frame_monitor failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // word builders
  // --------------------------------------------------------------------------
  function automatic in_word_t make_byte(logic [7:0] data, logic last, logic mgmt,
                                         logic [LengthBits-1:0] flen,
                                         logic signed [7:0] rssi, logic [7:0] chan);
    in_word_t w;
    w.opcode          = OP_BYTE;
    w.data_byte       = data;
    w.last_byte       = last;
    w.is_mgmt         = mgmt;
    w.frame_length    = flen;
    w.signal_strength = rssi;
    w.radio_channel   = chan;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.opcode          = 1'($urandom);
    w.data_byte       = 8'($urandom);
    w.last_byte       = 1'($urandom);
    w.is_mgmt         = 1'($urandom);
    w.frame_length    = LengthBits'($urandom);
    w.signal_strength = 8'($urandom);
    w.radio_channel   = 8'($urandom);
    return w;
  endfunction

  function automatic in_word_t drain_word();
    in_word_t w;
    w        = random_word();
    w.opcode = OP_DRAIN;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // drivers: inputs move at the falling edge, every task returns there
  // valid stays up between back-to-back words
  // --------------------------------------------------------------------------
  task push_word(in_word_t w);
    if (idling_on && $urandom_range(0, 15) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  // hold the sender until every owed result has come back
  task settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.due_reports.size() != 0) @(negedge clk_i);
  endtask

  // register write only with the block quiet, extra cycles for result-less words
  task write_detect(logic en);
    settle();
    repeat (SettleGap) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one frame of nbytes words; jitter varies the side fields on every byte
  task send_frame(logic [7:0] fc, logic mgmt, logic [LengthBits-1:0] flen,
                  int unsigned nbytes, bit jitter);
    in_word_t          w;
    logic signed [7:0] rssi;
    logic [7:0]        chan;
    rssi = 8'($urandom);
    chan = 8'($urandom);
    for (int unsigned i = 0; i < nbytes; i++) begin
      // health drain slipped into the middle of a frame now and then
      if ($urandom_range(0, 99) == 0) push_word(drain_word());
      w = make_byte((i == 0) ? fc : 8'($urandom), i == nbytes - 1, mgmt, flen, rssi, chan);
      if (jitter) begin
        w.is_mgmt         = 1'($urandom);
        w.frame_length    = LengthBits'($urandom);
        w.signal_strength = 8'($urandom);
        w.radio_channel   = 8'($urandom);
      end
      push_word(w);
    end
  endtask

  // frame-control byte 0: mostly probes, then deauth/disassoc, then anything
  function automatic logic [7:0] pick_fc();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return FcProbeReq;
    if (r < 7) return FcDeauth;
    if (r < 8) return FcDisassoc;
    return 8'($urandom);
  endfunction

  task random_frames(int unsigned budget);
    int unsigned           first;
    int unsigned           sel;
    int unsigned           n;
    logic [LengthBits-1:0] flen;
    first = words_sent;
    while ((words_sent - first) < budget) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        // well-formed frame, length as declared
        flen = LengthBits'($urandom_range(24, 56));
        send_frame(pick_fc(), 1'b1, flen, flen, 1'b0);
      end else if (sel < 70) begin
        // truncated: last byte comes early
        flen = LengthBits'($urandom_range(24, 56));
        send_frame(pick_fc(), 1'b1, flen, $urandom_range(1, flen - 1), 1'b0);
      end else if (sel < 80) begin
        // overlong: more bytes than the declared length
        flen = LengthBits'($urandom_range(0, 40));
        send_frame(pick_fc(), 1'b1, flen, flen + $urandom_range(1, 8), 1'b0);
      end else if (sel < 88) begin
        flen = LengthBits'(corner_lens[$urandom_range(0, 11)]);
        n    = (flen == 0) ? 1 : ((flen > 56) ? 56 : flen);
        send_frame(pick_fc(), 1'b1, flen, n, 1'b0);
      end else if (sel < 95) begin
        send_frame(pick_fc(), 1'($urandom), LengthBits'($urandom),
                   $urandom_range(1, 40), 1'b1);
      end else begin
        // loose noise words, drains among them
        repeat ($urandom_range(1, 4)) push_word(random_word());
      end
      if ($urandom_range(0, 3) == 0) push_word(drain_word());
      if ($urandom_range(0, 19) == 0) settle();
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    idling_on   = 1'b0;
    words_sent  = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: drain of empty counters
    push_word(drain_word());
    // single-byte frames, classified and counted on the same word
    push_word(make_byte(FcDeauth, 1'b1, 1'b1, HdrLen, 8'h80, 8'h00));
    push_word(make_byte(FcDisassoc, 1'b1, 1'b1, PosMax, 8'h7F, 8'hFF));
    // probe with no element room, then with one element byte never sent
    push_word(make_byte(FcProbeReq, 1'b1, 1'b1, NoIeLen, 8'hFF, 8'd1));
    push_word(make_byte(FcProbeReq, 1'b1, 1'b1, NoIeLen + 12'd1, 8'h00, 8'd6));
    // not management, too short, an ordinary management frame, then a zero-length one
    push_word(make_byte(FcProbeReq, 1'b1, 1'b0, 12'd100, 8'h05, 8'd11));
    push_word(make_byte(8'hFF, 1'b1, 1'b1, HdrLen - 12'd1, 8'h10, 8'd13));
    push_word(make_byte(8'hFF, 1'b1, 1'b1, HdrLen, 8'hF0, 8'd36));
    push_word(make_byte(8'h00, 1'b1, 1'b1, 12'd0, 8'h01, 8'd40));
    // second drain sees zero counts but keeps the channel
    push_word(drain_word());
    push_word(drain_word());
    // truncated probe: address cut short after byte 12
    for (int unsigned i = 0; i < 13; i++)
      push_word(make_byte((i == 0) ? FcProbeReq : ((i % 2 == 1) ? 8'hFF : 8'h00),
                          i == 12, 1'b1, 12'd30, 8'h9C, 8'd149));
    push_word(drain_word());

    // random phases across detection settings
    write_detect(1'b1);
    idling_on = 1'b1;
    random_frames(250);
    write_detect(1'b0);
    random_frames(200);
    write_detect(1'b1);
    random_frames(250);

    // last part without idling
    idling_on = 1'b0;
    push_word(drain_word());
    write_detect(1'b0);
    random_frames(100);
    write_detect(1'b1);
    random_frames(200);

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_wifi_mgmt_frame_monitor passed");
    end else begin
      $display("tb_wifi_mgmt_frame_monitor failed");
    end
    $finish;
  end

endmodule
